@@ sv/rrts_pkg.sv @@
// ============================================================================
// rrts_pkg - shared types and constants for the round-robin task scheduler
// Field widths, action codes, the queue entry type and parameter defaults.
// ============================================================================
`default_nettype none

package rrts_pkg;

    // Field widths
    localparam int ID_W      = 4;
    localparam int T_W       = 14;
    localparam int QUANTUM_W = 8;

    // Task ids index a fixed table of arrival times
    localparam int ID_SLOTS = 1 << ID_W;

    // Parameter defaults
    localparam int MAX_TASKS_DEF = 16;

    // Quantum register value after reset
    localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd1;

    // Action codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_ARRIVE = 1'b1;

    // One queued task: id and remaining demand
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [T_W-1:0]  rem;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/round_robin_task_scheduler.sv @@
// ============================================================================
// round_robin_task_scheduler - round-robin scheduler with a time quantum
// Queues arriving tasks and runs the head task one time unit per tick item,
// reporting the running task and, on completion, finish and turnaround time.
// ============================================================================
// The block takes one item in every clock cycle: busy is never raised, so
// start alone decides acceptance. An arrive item (action = 1) appends a task
// to the FIFO and stamps it with the current time; it is dropped when the
// queue plus a held task already fill all MAX_TASKS slots, and it gives no
// result. A tick item (action = 0) gives exactly one result, shown on the
// o_ ports with o_valid high in the cycle after the tick is taken. The
// receiver cannot stall: o_valid lasts one cycle and must be captured then.
// Each tick first requeues a task that was preempted on the previous tick,
// then runs the head task for one unit. The FIFO lives in a memory with a
// registered read port; the head entry and the entry behind it are kept in
// registers so a pop need not wait on a read. Memory contents need no clearing
// after reset, so the block is ready once reset is released.
// Writing the quantum register also reloads the running quantum counter;
// write it only while no item is in flight.
// ============================================================================
`default_nettype none

module round_robin_task_scheduler #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_action,
    input  wire logic [rrts_pkg::ID_W-1:0]      i_task_id,
    input  wire logic [rrts_pkg::T_W-1:0]       i_service_demand,
    // Quantum register
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [rrts_pkg::QUANTUM_W-1:0] i_cfg_wr_data,
    // Result channel
    output logic                                o_valid,
    output logic                                o_busy_res,
    output logic [rrts_pkg::ID_W-1:0]           o_running_id,
    output logic                                o_finished,
    output logic [rrts_pkg::T_W-1:0]            o_finish_time,
    output logic [rrts_pkg::T_W-1:0]            o_turnaround
);

    localparam int PTR_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_TASKS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TASKS);

    // Circular pointer advance, wraps at any depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    rrts_pkg::t_entry                   mem_q [MAX_TASKS];
    logic [rrts_pkg::T_W-1:0]           r_arrival [rrts_pkg::ID_SLOTS];

    logic [PTR_W-1:0]                   r_head_ptr, n_head_ptr;
    logic [PTR_W-1:0]                   r_tail_ptr, n_tail_ptr;
    logic [CNT_W-1:0]                   r_count,    n_count;
    logic                               r_pend_vld, n_pend_vld;
    rrts_pkg::t_entry                   r_pend,     n_pend;
    rrts_pkg::t_entry                   r_head,     n_head;
    rrts_pkg::t_entry                   r_nxt;
    logic [rrts_pkg::QUANTUM_W-1:0]     r_quantum,  n_quantum;
    logic [rrts_pkg::QUANTUM_W-1:0]     r_ql,       n_ql;
    logic [rrts_pkg::T_W-1:0]           r_time,     n_time;

    logic                               r_valid;
    logic                               r_busy_res;
    logic [rrts_pkg::ID_W-1:0]          r_running_id;
    logic                               r_finished;
    logic [rrts_pkg::T_W-1:0]           r_finish_time;
    logic [rrts_pkg::T_W-1:0]           r_turnaround;

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    logic                               acc, is_tick, is_arr, arr_ok;
    logic                               wr_en;
    rrts_pkg::t_entry                   wr_data;
    logic [CNT_W-1:0]                   count1;
    rrts_pkg::t_entry                   eh, en;
    logic [PTR_W-1:0]                   head_inc, rd_addr;
    logic                               run, done, expired, pop;
    logic [rrts_pkg::T_W-1:0]           end_time, arr_time;
    logic [rrts_pkg::T_W-1:0]           rem_dec;

    assign busy    = 1'b0;
    assign acc     = start & ~busy;
    assign is_tick = acc && (i_action == rrts_pkg::ACT_TICK);
    assign is_arr  = acc && (i_action == rrts_pkg::ACT_ARRIVE);

    // Leave room for a held task so its requeue never fails
    assign arr_ok = (({1'b0, r_count} + (CNT_W+1)'(r_pend_vld)) < {1'b0, CNT_MAX});

    // One FIFO write per item: the new arrival, or the held task on a tick
    assign wr_en = (is_arr && arr_ok) || (is_tick && r_pend_vld && (r_count < CNT_MAX));
    assign wr_data = is_arr ? rrts_pkg::t_entry'{id: i_task_id, rem: i_service_demand}
                            : r_pend;

    assign count1 = r_count + CNT_W'(wr_en);

    // Head as seen after this item's push: the pushed entry when empty
    assign eh       = (r_count == '0) ? wr_data : r_head;
    assign head_inc = ptr_inc(r_head_ptr);
    // Entry behind the head; bypass a push landing right there
    assign en       = (wr_en && (r_tail_ptr == head_inc)) ? wr_data : r_nxt;

    assign run      = is_tick && (count1 != '0);
    assign done     = (eh.rem <= rrts_pkg::T_W'(1));
    assign expired  = (r_ql <= rrts_pkg::QUANTUM_W'(1));
    assign pop      = run && (done || expired);
    assign rem_dec  = eh.rem - 1'b1;
    assign end_time = r_time + 1'b1;
    assign arr_time = r_arrival[eh.id];

    always_comb begin
        n_tail_ptr = wr_en ? ptr_inc(r_tail_ptr) : r_tail_ptr;
        n_head_ptr = pop ? head_inc : r_head_ptr;
        n_count    = count1 - CNT_W'(pop);

        // Hold head, advance to next on pop, count down while it runs
        if (pop) begin
            n_head = en;
        end else if (run) begin
            n_head = rrts_pkg::t_entry'{id: eh.id, rem: rem_dec};
        end else begin
            n_head = eh;
        end

        // A tick always consumes the held task; preempt sets a new one
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        if (is_tick) begin
            n_pend_vld = run && !done && expired;
            n_pend     = rrts_pkg::t_entry'{id: eh.id, rem: rem_dec};
        end

        n_quantum = i_cfg_wr_en ? i_cfg_wr_data : r_quantum;

        if (i_cfg_wr_en) begin
            n_ql = i_cfg_wr_data;
        end else if (pop) begin
            n_ql = r_quantum;
        end else if (run) begin
            n_ql = r_ql - 1'b1;
        end else begin
            n_ql = r_ql;
        end

        n_time = is_tick ? end_time : r_time;
    end

    assign rd_addr = ptr_inc(n_head_ptr);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr <= '0;
            r_tail_ptr <= '0;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_quantum  <= rrts_pkg::QUANTUM_RST;
            r_ql       <= rrts_pkg::QUANTUM_RST;
            r_time     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_head_ptr <= n_head_ptr;
            r_tail_ptr <= n_tail_ptr;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_quantum  <= n_quantum;
            r_ql       <= n_ql;
            r_time     <= n_time;
            r_valid    <= is_tick;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_head        <= n_head;
        r_pend        <= n_pend;
        r_busy_res    <= run;
        r_running_id  <= run ? eh.id : '0;
        r_finished    <= run && done;
        r_finish_time <= (run && done) ? end_time : '0;
        r_turnaround  <= (run && done) ? (end_time - arr_time) : '0;
    end

    // ------------------------------------------------------------------
    // FIFO memory: one write at tail, one registered read behind the head
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_q[r_tail_ptr] <= wr_data;
        end
        r_nxt <= (wr_en && (r_tail_ptr == rd_addr)) ? wr_data : mem_q[rd_addr];
    end

    // Arrival stamps, indexed by task id
    always_ff @(posedge i_clk) begin
        if (is_arr && arr_ok) begin
            r_arrival[i_task_id] <= r_time;
        end
    end

    assign o_valid       = r_valid;
    assign o_busy_res    = r_busy_res;
    assign o_running_id  = r_running_id;
    assign o_finished    = r_finished;
    assign o_finish_time = r_finish_time;
    assign o_turnaround  = r_turnaround;

endmodule

`default_nettype wire

@@ sv/rrts_chk.sv @@
// ============================================================================
// rrts_chk - port-level checks for the round-robin task scheduler
// Relates accepted items to result strobes and checks result consistency.
// ============================================================================
`default_nettype none

module rrts_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      i_action,
    input wire logic                      o_valid,
    input wire logic                      o_busy_res,
    input wire logic [rrts_pkg::ID_W-1:0] o_running_id,
    input wire logic                      o_finished,
    input wire logic [rrts_pkg::T_W-1:0]  o_finish_time,
    input wire logic [rrts_pkg::T_W-1:0]  o_turnaround
);

    logic tick_acc;
    logic arr_acc;

    assign tick_acc = start && !busy && (i_action == rrts_pkg::ACT_TICK);
    assign arr_acc  = start && !busy && (i_action == rrts_pkg::ACT_ARRIVE);

    // Every accepted tick gives a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> o_valid)
        else $error("tick item gave no result");

    // Arrivals give no result
    a_arrive_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arr_acc |=> !o_valid)
        else $error("arrive item gave a result");

    // No result without an accepted tick
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(tick_acc) && $past(i_rst_n)))
        else $error("result without tick item");

    // A finish needs a running task
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> o_busy_res)
        else $error("finish reported on an idle tick");

    // Idle and unfinished ticks carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_finished) |->
            ((o_finish_time == '0) && (o_turnaround == '0) &&
             (o_busy_res || (o_running_id == '0))))
        else $error("nonzero fields on a result without finish");

endmodule

bind round_robin_task_scheduler rrts_chk u_rrts_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .o_busy_res    (o_busy_res),
    .o_running_id  (o_running_id),
    .o_finished    (o_finished),
    .o_finish_time (o_finish_time),
    .o_turnaround  (o_turnaround)
);

`default_nettype wire
